[src/mpq_pkg.sv]
`default_nettype none

package mpq_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 16;
    localparam int DOC_W    = 16;
    localparam int STAMP_W  = 32;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [DOC_W-1:0]   doc;
        logic [KEY_W-1:0]   key;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] key;
        logic [DOC_W-1:0] doc;
        logic             relevant;
    } res_t;

    // true when entry a leaves before entry b
    function automatic logic ahead(input entry_t a, input entry_t b);
        logic r;
        if (a.key != b.key)
        begin
            r = (a.key > b.key);
        end
        else
        begin
            r = (a.stamp < b.stamp);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/mpq_store.sv]
`default_nettype none

module mpq_store (
    input  wire logic                     clk,
    input  wire mpq_pkg::mem_wr_t         wr,
    input  wire logic [mpq_pkg::IDX_W-1:0] raddr,
    output mpq_pkg::entry_t               rdata
);

    mpq_pkg::entry_t mem [mpq_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/mpq_ctrl.sv]
`default_nettype none

module mpq_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       cmd,
    input  wire logic [mpq_pkg::KEY_W-1:0]  key,
    input  wire logic [mpq_pkg::DOC_W-1:0]  doc_id,
    output mpq_pkg::mem_wr_t                mem_wr,
    output logic [mpq_pkg::IDX_W-1:0]       mem_raddr,
    input  wire mpq_pkg::entry_t            mem_rdata,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output mpq_pkg::res_t                   res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [mpq_pkg::CNT_W-1:0]     occ_reg, occ_next;
    logic [mpq_pkg::STAMP_W-1:0]   arr_reg, arr_next;
    logic [mpq_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [mpq_pkg::IDX_W-1:0]     best_idx_reg, best_idx_next;
    mpq_pkg::entry_t               best_reg, best_next;
    mpq_pkg::entry_t               last_reg, last_next;
    mpq_pkg::res_t                 res_reg, res_next;

    logic                          in_fire;
    logic                          full;
    logic                          scan_last;
    logic                          take;
    logic [mpq_pkg::CNT_W-1:0]     occ_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign full      = (occ_reg == mpq_pkg::CNT_W'(mpq_pkg::CAPACITY));
    assign occ_last  = occ_reg - mpq_pkg::CNT_W'(1);
    assign scan_last = (mpq_pkg::CNT_W'(idx_reg) == occ_last);
    // first beat of the scan seeds the running best
    assign take      = (idx_reg == '0) || mpq_pkg::ahead(mem_rdata, best_reg);
    assign mem_raddr = (state_reg == S_SCAN) ? idx_reg + mpq_pkg::IDX_W'(1) : '0;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        arr_next      = arr_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        last_next     = last_reg;
        res_next      = res_reg;
        mem_wr.we     = 1'b0;
        mem_wr.addr   = occ_reg[mpq_pkg::IDX_W-1:0];
        mem_wr.data   = '{stamp: arr_reg, doc: doc_id, key: key};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_next = '0;
                    if (cmd == mpq_pkg::CMD_INSERT)
                    begin
                        state_next = S_DONE;
                        if (full)
                        begin
                            res_next.status = mpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            res_next.status = mpq_pkg::ST_DONE;
                            mem_wr.we       = 1'b1;
                            occ_next        = occ_reg + mpq_pkg::CNT_W'(1);
                            arr_next        = arr_reg + mpq_pkg::STAMP_W'(1);
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        res_next.status = mpq_pkg::ST_EMPTY;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    best_next     = mem_rdata;
                    best_idx_next = idx_reg;
                end
                if (scan_last)
                begin
                    last_next  = mem_rdata;
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + mpq_pkg::IDX_W'(1);
                end
            end
            S_WRITE:
            begin
                // last occupied entry fills the hole
                mem_wr.we         = 1'b1;
                mem_wr.addr       = best_idx_reg;
                mem_wr.data       = last_reg;
                occ_next          = occ_last;
                res_next.status   = mpq_pkg::ST_DONE;
                res_next.key      = best_reg.key;
                res_next.doc      = best_reg.doc;
                res_next.relevant = (best_reg.key != '0);
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            arr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            arr_reg   <= arr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        last_reg     <= last_next;
        res_reg      <= res_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= mpq_pkg::CNT_W'(mpq_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> mpq_pkg::CNT_W'(idx_reg) < occ_reg)
        else $error("scan index past occupancy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_reg.status == mpq_pkg::ST_FULL |-> full)
        else $error("full status while not full");

    a_extract_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && cmd == mpq_pkg::CMD_EXTRACT && occ_reg != '0 |=> state_reg == S_SCAN)
        else $error("extract on non-empty queue did not start scan");

    a_extract_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |=> occ_reg == $past(occ_reg) - mpq_pkg::CNT_W'(1))
        else $error("extract did not shrink occupancy");

endmodule

`default_nettype wire

[src/max_priority_queue.sv]
// Max-priority queue of up to 256 document entries (16-bit score, 16-bit id). An insert
// beat writes the entry into the next free slot. For an extract beat, one comparator walks
// the single read port of the entry memory one slot per cycle to find the highest score
// (earliest insertion wins a tie), then the last entry is moved into the freed slot. The
// block takes one beat at a time; a finished result sits in an output register, so the
// next beat is accepted while it waits to be taken.
`default_nettype none

module max_priority_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       cmd,
    input  wire logic [mpq_pkg::KEY_W-1:0]  key,
    input  wire logic [mpq_pkg::DOC_W-1:0]  doc_id,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      status,
    output logic [mpq_pkg::KEY_W-1:0]       out_key,
    output logic [mpq_pkg::DOC_W-1:0]       out_doc,
    output logic                            relevant
);

    mpq_pkg::mem_wr_t              mem_wr;
    logic [mpq_pkg::IDX_W-1:0]     mem_raddr;
    mpq_pkg::entry_t               mem_rdata;
    logic                          res_valid;
    logic                          res_ready;
    mpq_pkg::res_t                 res;

    logic                          out_valid_reg;
    mpq_pkg::res_t                 out_res_reg;

    mpq_store u_store (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key       (key),
        .doc_id    (doc_id),
        .mem_wr    (mem_wr),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register frees up when its beat is taken
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign out_key   = out_res_reg.key;
    assign out_doc   = out_res_reg.doc;
    assign relevant  = out_res_reg.relevant;

endmodule

`default_nettype wire
